// File: rtl/kmer_hash_counter_defines.svh
// assertion macros for the k-mer hash counter
// used by the top level; no other dependencies
`ifndef KMER_HASH_COUNTER_DEFINES_SVH
`define KMER_HASH_COUNTER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define KHC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kmer_hash_counter: assertion failed");

// next-cycle implication
`define KHC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kmer_hash_counter: assertion failed");

`else

`define KHC_ASSERT_IMP(label, clk, rst, ante, cons)
`define KHC_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/khc_pkg.sv
// shared constants, types and codes of the k-mer hash counter
// no dependencies
package khc_pkg;

  // table geometry
  localparam int BUCKETS     = 1021;
  localparam int WAYS        = 4;
  localparam int COUNT_BITS  = 32;
  localparam int SLOTS       = BUCKETS * WAYS;
  localparam int BUCKET_BITS = $clog2(BUCKETS);
  localparam int WAY_BITS    = $clog2(WAYS);

  // field widths
  localparam int KEY_BITS       = 48;
  localparam int SLOT_BITS      = 12;
  localparam int STATUS_BITS    = 2;
  localparam int OUT_COUNT_BITS = 32;
  localparam int IN_TDATA_BITS  = ((KEY_BITS + SLOT_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((1 + KEY_BITS + OUT_COUNT_BITS + 7) / 8) * 8;

  // hash: h = (h * 31 + byte) mod BUCKETS, 31 taken as (h << 5) - h
  localparam int HASH_MUL_SH   = 5;
  localparam int HASH_MUL      = (1 << HASH_MUL_SH) - 1;
  localparam int BYTE_BITS     = 8;
  localparam int BLOCK_BYTES   = 6;
  localparam int BYTE_CNT_BITS = $clog2(BLOCK_BYTES);
  localparam int HX_MAX        = (BUCKETS - 1) * HASH_MUL + 255;
  localparam int HX_BITS       = $clog2(HX_MAX + 1);
  localparam int HASH_SH       = HX_BITS + BUCKET_BITS;
  localparam longint HASH_RECIP = (longint'(1) << HASH_SH) / BUCKETS;
  localparam int RECIP_BITS    = $clog2(HASH_RECIP + 1);
  localparam int PROD_BITS     = HX_BITS + RECIP_BITS;

  // request kinds
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  // result status codes
  localparam logic [STATUS_BITS-1:0] ST_HIT  = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_NEW  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_READ = 2'd3;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // one way of a bucket row
  typedef struct packed {
    logic                  valid;
    logic [KEY_BITS-1:0]   key;
    logic [COUNT_BITS-1:0] count;
  } entry_t;

  typedef entry_t [WAYS-1:0] row_t;

  // hash unit response
  typedef struct packed {
    logic                   done;
    logic [BUCKET_BITS-1:0] bucket;
  } hash_rsp_t;

endpackage

// File: rtl/khc_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module khc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/khc_hash.sv
// iterative bucket hash of a six-byte block, one byte at a time, each in an estimate phase and a remainder phase
// depends on khc_pkg
module khc_hash import khc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [KEY_BITS-1:0] key,
  output hash_rsp_t           rsp
);

  logic                     busy;
  logic                     phase;
  logic                     done;
  logic [BYTE_CNT_BITS-1:0] cnt;
  logic [KEY_BITS-1:0]      keysh;
  logic [BUCKET_BITS-1:0]   h;
  logic [HX_BITS-1:0]       x;
  logic [HX_BITS-1:0]       q;
  logic [HX_BITS-1:0]       x_next;
  logic [PROD_BITS-1:0]     prod;
  logic [HX_BITS-1:0]       q_next;
  logic [HX_BITS-1:0]       rem;
  logic [HX_BITS-1:0]       rem_fix;

  // first phase: x = h * 31 + byte, estimate quotient by reciprocal
  always_comb begin
    x_next = (HX_BITS'(h) << HASH_MUL_SH) - HX_BITS'(h)
             + HX_BITS'(keysh[KEY_BITS-1 -: BYTE_BITS]);
    prod   = PROD_BITS'(x_next) * PROD_BITS'(HASH_RECIP);
    q_next = HX_BITS'(prod >> HASH_SH);
  end

  // second phase: remainder, one correction since estimate is at most one low
  always_comb begin
    rem     = x - q * HX_BITS'(BUCKETS);
    rem_fix = (rem >= HX_BITS'(BUCKETS)) ? rem - HX_BITS'(BUCKETS) : rem;
  end

  // byte sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        cnt   <= '0;
        h     <= '0;
        keysh <= key;
      end else if (busy) begin
        if (!phase) begin
          x     <= x_next;
          q     <= q_next;
          phase <= 1'b1;
        end else begin
          h     <= BUCKET_BITS'(rem_fix);
          phase <= 1'b0;
          keysh <= keysh << BYTE_BITS;
          if (cnt == BYTE_CNT_BITS'(BLOCK_BYTES - 1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.bucket = h;

endmodule

// File: rtl/kmer_hash_counter.sv
// Counts occurrences of six-byte blocks in a bucketed, 4-way table held in one
// row-wide memory (one row per bucket). After reset a clearing pass writes every
// bucket row, during which no transfer is taken. An insert runs the hash unit over
// each of the six bytes in turn, then a memory read, a read-modify-write and an
// output step follow. A slot read takes a memory read, way select and output. One
// request is in flight at a time; the next is taken once the result sits in the
// output register.
// depends on khc_pkg, khc_ram, khc_hash and kmer_hash_counter_defines.svh
`include "kmer_hash_counter_defines.svh"

module kmer_hash_counter import khc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // key_block [47:0], slot_index [59:48], zero pad
  input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
  // req_type [0]
  input  logic [0:0]                s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // entry_valid [0], entry_block [48:1], entry_count [80:49], zero pad
  output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
  // status [1:0]
  output logic [STATUS_BITS-1:0]    m_axis_tuser
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_ISSUE = 3'd3;
  localparam logic [2:0] S_LOOK  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]                state;
  logic [2:0]                state_next;
  logic [BUCKET_BITS-1:0]    clr_addr;
  logic                      req_reg;
  logic [KEY_BITS-1:0]       key_reg;
  logic [WAY_BITS-1:0]       idx_reg;
  logic [BUCKET_BITS-1:0]    bucket;
  logic                      oor;
  logic [STATUS_BITS-1:0]    res_status;
  logic                      res_valid;
  logic [KEY_BITS-1:0]       res_block;
  logic [OUT_COUNT_BITS-1:0] res_count;
  logic [STATUS_BITS-1:0]    out_status;
  logic                      out_valid;
  logic [KEY_BITS-1:0]       out_block;
  logic [OUT_COUNT_BITS-1:0] out_count;

  logic                      in_xfer;
  logic                      load_out;
  logic                      hash_start;
  hash_rsp_t                 hash_rsp;

  logic                      ram_wr_en;
  logic [BUCKET_BITS-1:0]    ram_wr_addr;
  row_t                      ram_wr_data;
  logic                      ram_rd_en;
  row_t                      ram_rd_data;

  logic                      hit;
  logic                      free;
  logic [WAY_BITS-1:0]       hit_way;
  logic [WAY_BITS-1:0]       free_way;
  logic [COUNT_BITS-1:0]     sat_count;
  row_t                      upd_row;
  entry_t                    rd_ent;
  logic [STATUS_BITS-1:0]    look_status;
  logic                      look_valid;
  logic [KEY_BITS-1:0]       look_block;
  logic [OUT_COUNT_BITS-1:0] look_count;
  logic                      look_write;

  assign s_axis_tready = (state == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign load_out      = (state == S_DONE) && (!m_axis_tvalid || m_axis_tready);
  assign hash_start    = in_xfer && (s_axis_tuser[0] == REQ_INSERT);

  khc_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (s_axis_tdata[KEY_BITS-1:0]),
    .rsp   (hash_rsp)
  );

  khc_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (BUCKETS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (bucket),
    .rd_data (ram_rd_data)
  );

  // way search over the bucket row just read
  always_comb begin
    hit      = 1'b0;
    free     = 1'b0;
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (ram_rd_data[w].valid && ram_rd_data[w].key == key_reg && !hit) begin
        hit     = 1'b1;
        hit_way = WAY_BITS'(w);
      end
      if (!ram_rd_data[w].valid && !free) begin
        free     = 1'b1;
        free_way = WAY_BITS'(w);
      end
    end
  end

  // row update and result of the looked-up request
  always_comb begin
    sat_count   = ram_rd_data[hit_way].count;
    if (sat_count != COUNT_MAX) begin
      sat_count = sat_count + 1'b1;
    end
    upd_row     = ram_rd_data;
    rd_ent      = ram_rd_data[idx_reg];
    look_write  = 1'b0;
    look_status = ST_READ;
    look_valid  = 1'b0;
    look_block  = '0;
    look_count  = '0;
    if (req_reg == REQ_READ) begin
      if (!oor && rd_ent.valid) begin
        look_valid = 1'b1;
        look_block = rd_ent.key;
        look_count = OUT_COUNT_BITS'(rd_ent.count);
      end
    end else if (hit) begin
      upd_row[hit_way].count = sat_count;
      look_write  = 1'b1;
      look_status = ST_HIT;
      look_valid  = 1'b1;
      look_block  = key_reg;
      look_count  = OUT_COUNT_BITS'(sat_count);
    end else if (free) begin
      upd_row[free_way].valid = 1'b1;
      upd_row[free_way].key   = key_reg;
      upd_row[free_way].count = COUNT_BITS'(1);
      look_write  = 1'b1;
      look_status = ST_NEW;
      look_valid  = 1'b1;
      look_block  = key_reg;
      look_count  = OUT_COUNT_BITS'(1);
    end else begin
      look_status = ST_FULL;
      look_block  = key_reg;
    end
  end

  // memory port control: clearing sweep or write-back
  always_comb begin
    ram_rd_en = (state == S_ISSUE);
    if (state == S_CLEAR) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = clr_addr;
      ram_wr_data = '0;
    end else begin
      ram_wr_en   = (state == S_LOOK) && look_write;
      ram_wr_addr = bucket;
      ram_wr_data = upd_row;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == BUCKET_BITS'(BUCKETS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          state_next = (s_axis_tuser[0] == REQ_READ) ? S_ISSUE : S_HASH;
        end
      end
      S_HASH: begin
        if (hash_rsp.done) begin
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: state_next = S_LOOK;
      S_LOOK:  state_next = S_DONE;
      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_reg <= s_axis_tuser[0];
      key_reg <= s_axis_tdata[KEY_BITS-1:0];
      idx_reg <= s_axis_tdata[KEY_BITS +: WAY_BITS];
      oor     <= (s_axis_tdata[KEY_BITS +: SLOT_BITS] >= SLOT_BITS'(SLOTS));
      if (s_axis_tdata[KEY_BITS +: SLOT_BITS] >= SLOT_BITS'(SLOTS)) begin
        bucket <= '0;
      end else begin
        bucket <= BUCKET_BITS'(s_axis_tdata[KEY_BITS +: SLOT_BITS] >> WAY_BITS);
      end
    end else if (state == S_HASH && hash_rsp.done) begin
      bucket <= hash_rsp.bucket;
    end
    if (state == S_LOOK) begin
      res_status <= look_status;
      res_valid  <= look_valid;
      res_block  <= look_block;
      res_count  <= look_count;
    end
    if (load_out) begin
      out_status <= res_status;
      out_valid  <= res_valid;
      out_block  <= res_block;
      out_count  <= res_count;
    end
  end

  assign m_axis_tdata = OUT_TDATA_BITS'({out_count, out_block, out_valid});
  assign m_axis_tuser = out_status;

  // the table is never read and written in the same cycle
  `KHC_ASSERT_IMP(a_rw_apart, clk, rst, ram_wr_en, !ram_rd_en)
  // write-backs only come from an insert lookup or the clearing sweep
  `KHC_ASSERT_IMP(a_wr_src, clk, rst, ram_wr_en && state != S_CLEAR,
    state == S_LOOK && req_reg == REQ_INSERT)
  // a new entry always reports a count of one
  `KHC_ASSERT_IMP(a_new_one, clk, rst, load_out && res_status == ST_NEW,
    res_count == OUT_COUNT_BITS'(1) && res_valid)
  // the hash unit only answers while the sequencer waits for it
  `KHC_ASSERT_IMP(a_hash_wait, clk, rst, hash_rsp.done, state == S_HASH)
  // a lookup is always followed by a result waiting for output
  `KHC_ASSERT_NXT(a_look_done, clk, rst, state == S_LOOK, state == S_DONE)

endmodule
